// ===== design/hcb_pkg.sv =====
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared command and status types for the Huffman code builder.
// ----------------------------------------------------------------------------
package hcb_pkg;

	localparam int unsigned CodeBits = 15;
	localparam int unsigned SymBits  = 4;
	localparam int unsigned LenBits  = 4;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_START,
		OP_NEWNODE,
		OP_SCAN,
		OP_MARK_A,
		OP_MERGE,
		OP_LEAF,
		OP_FIRST,
		OP_EVAL,
		OP_EMIT
	} hcb_op_t;

	typedef struct packed {
		hcb_op_t op;
	} hcb_cmd_t;

	typedef struct packed {
		logic cnt_ge2;
		logic build_done;
		logic scan_last;
		logic walk_more;
		logic leaf_last;
		logic emit_ok;
	} hcb_status_t;

endpackage

// ===== design/hcb_ram.sv =====
// ----------------------------------------------------------------------------
// hcb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hcb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/hcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// hcb_ctrl
// Sequencer for load, tree build and code walk.
// ----------------------------------------------------------------------------
module hcb_ctrl
	import hcb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        last_weight,
	output logic        in_ready,
	input  hcb_status_t status,
	output hcb_cmd_t    cmd
);

	typedef enum logic [11:0] {
		S_LOAD    = 12'b0000_0000_0001,
		S_START   = 12'b0000_0000_0010,
		S_NEWNODE = 12'b0000_0000_0100,
		S_SCAN_A  = 12'b0000_0000_1000,
		S_DRAIN_A = 12'b0000_0001_0000,
		S_MARK_A  = 12'b0000_0010_0000,
		S_SCAN_B  = 12'b0000_0100_0000,
		S_DRAIN_B = 12'b0000_1000_0000,
		S_MERGE   = 12'b0001_0000_0000,
		S_LEAF    = 12'b0010_0000_0000,
		S_FIRST   = 12'b0100_0000_0000,
		S_WALK    = 12'b1000_0000_0000
	} hcb_state_t;

	hcb_state_t state_q, state_d;
	logic       emit_q, emit_d;

	assign in_ready = (state_q == S_LOAD) && !emit_q;

	always_comb begin
		state_d = state_q;
		emit_d  = emit_q;
		cmd.op  = OP_NONE;
		if (emit_q) begin
			// hold until the output register is free
			if (status.emit_ok) begin
				cmd.op = OP_EMIT;
				emit_d = 1'b0;
				state_d = status.leaf_last ? S_LOAD : S_LEAF;
			end
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						cmd.op = OP_LOAD;
						if (last_weight) state_d = S_START;
					end
				end
				S_START: begin
					cmd.op  = OP_START;
					state_d = status.cnt_ge2 ? S_NEWNODE : S_LOAD;
				end
				S_NEWNODE: begin
					if (status.build_done) begin
						state_d = S_LEAF;
					end else begin
						cmd.op  = OP_NEWNODE;
						state_d = S_SCAN_A;
					end
				end
				S_SCAN_A: begin
					cmd.op = OP_SCAN;
					if (status.scan_last) state_d = S_DRAIN_A;
				end
				S_DRAIN_A: state_d = S_MARK_A;
				S_MARK_A: begin
					cmd.op  = OP_MARK_A;
					state_d = S_SCAN_B;
				end
				S_SCAN_B: begin
					cmd.op = OP_SCAN;
					if (status.scan_last) state_d = S_DRAIN_B;
				end
				S_DRAIN_B: state_d = S_MERGE;
				S_MERGE: begin
					cmd.op  = OP_MERGE;
					state_d = S_NEWNODE;
				end
				S_LEAF: begin
					cmd.op  = OP_LEAF;
					state_d = S_FIRST;
				end
				S_FIRST: begin
					cmd.op = OP_FIRST;
					if (status.walk_more) state_d = S_WALK;
					else emit_d = 1'b1;
				end
				S_WALK: begin
					cmd.op = OP_EVAL;
					if (!status.walk_more) emit_d = 1'b1;
				end
				default: state_d = S_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			emit_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			emit_q  <= emit_d;
		end
	end

endmodule

// ===== design/hcb_dp.sv =====
// ----------------------------------------------------------------------------
// hcb_dp
// Node table, minimum search, code walk and output register.
// ----------------------------------------------------------------------------
module hcb_dp
	import hcb_pkg::*;
#(
	parameter int unsigned MAX_SYMBOLS = 16,
	parameter int unsigned WEIGHT_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hcb_cmd_t               cmd,
	output hcb_status_t            status,
	input  logic [WEIGHT_BITS-1:0] weight,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [SymBits-1:0]     symbol,
	output logic [CodeBits-1:0]    code_bits,
	output logic [LenBits-1:0]     code_length,
	output logic                   last_code
);

	localparam int unsigned Nodes = 2 * MAX_SYMBOLS - 1;
	localparam int unsigned NIW   = $clog2(Nodes);
	localparam int unsigned CW    = $clog2(MAX_SYMBOLS + 1);
	localparam int unsigned WNB   = WEIGHT_BITS + $clog2(MAX_SYMBOLS);

	logic [CW-1:0]  cnt_q, n_q;
	logic [NIW-1:0] node_q, j_q, j_s1, best_q, a_q, leaf_q, cur_q, f_q, len_q;
	logic [WNB-1:0] best_w_q, wa_q;
	logic           rd_s1, found_q, out_valid_q;
	logic [CodeBits-1:0] code_q;

	logic [NIW-1:0] m;
	logic [NIW-1:0] raddr, p_waddr, w_waddr, p_wdata, p_rd, l_rd;
	logic           w_we, p_we, l_we;
	logic [WNB-1:0] w_wdata, w_rd;
	logic           better;

	assign m = NIW'({n_q, 1'b0} - 1'b1);

	always_comb begin
		raddr   = j_q;
		w_we    = 1'b0;
		w_waddr = node_q;
		w_wdata = wa_q + best_w_q;
		p_we    = 1'b0;
		p_waddr = node_q;
		p_wdata = '0;
		l_we    = (cmd.op == OP_MERGE);
		case (cmd.op)
			OP_LOAD: begin
				w_we    = (cnt_q < CW'(MAX_SYMBOLS));
				w_waddr = NIW'(cnt_q);
				w_wdata = WNB'(weight);
				p_we    = w_we;
				p_waddr = NIW'(cnt_q);
			end
			OP_NEWNODE: p_we = 1'b1;
			OP_MARK_A, OP_MERGE: begin
				p_we    = 1'b1;
				p_waddr = best_q;
				p_wdata = node_q;
				w_we    = (cmd.op == OP_MERGE);
			end
			OP_LEAF: raddr = leaf_q;
			OP_FIRST, OP_EVAL: raddr = p_rd;
			default: raddr = j_q;
		endcase
	end

	hcb_ram #(.WIDTH(WNB), .DEPTH(Nodes)) u_weight (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(raddr), .rdata(w_rd)
	);
	hcb_ram #(.WIDTH(NIW), .DEPTH(Nodes)) u_parent (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(raddr), .rdata(p_rd)
	);
	hcb_ram #(.WIDTH(NIW), .DEPTH(Nodes)) u_left (
		.clk(clk), .we(l_we), .waddr(node_q), .wdata(a_q),
		.raddr(raddr), .rdata(l_rd)
	);

	assign better = rd_s1 && (p_rd == '0) && (!found_q || (w_rd < best_w_q));

	assign status.cnt_ge2    = (cnt_q >= CW'(2));
	assign status.build_done = (node_q == m);
	assign status.scan_last  = (j_q == node_q - 1'b1);
	assign status.walk_more  = (p_rd != '0);
	assign status.leaf_last  = (leaf_q == NIW'(n_q - 1'b1));
	assign status.emit_ok    = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= (cmd.op == OP_SCAN);
			if (cmd.op == OP_LOAD && cnt_q < CW'(MAX_SYMBOLS)) cnt_q <= cnt_q + 1'b1;
			if (cmd.op == OP_START) cnt_q <= '0;
			if (cmd.op == OP_EMIT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		j_s1 <= j_q;
		if (better) begin
			best_q   <= j_s1;
			best_w_q <= w_rd;
			found_q  <= 1'b1;
		end
		case (cmd.op)
			OP_START: begin
				n_q    <= cnt_q;
				node_q <= NIW'(cnt_q);
				leaf_q <= '0;
			end
			OP_NEWNODE: begin
				j_q     <= '0;
				found_q <= 1'b0;
			end
			OP_SCAN: j_q <= j_q + 1'b1;
			OP_MARK_A: begin
				a_q     <= best_q;
				wa_q    <= best_w_q;
				j_q     <= '0;
				found_q <= 1'b0;
			end
			OP_MERGE: node_q <= node_q + 1'b1;
			OP_LEAF: begin
				cur_q  <= leaf_q;
				code_q <= '0;
				len_q  <= '0;
			end
			OP_FIRST: f_q <= p_rd;
			OP_EVAL: begin
				// right child when the left pointer differs from where we came from
				if (l_rd != cur_q && len_q < NIW'(CodeBits)) begin
					code_q <= code_q | (CodeBits'(1) << len_q);
				end
				len_q <= len_q + 1'b1;
				cur_q <= f_q;
				f_q   <= p_rd;
			end
			OP_EMIT: begin
				symbol      <= SymBits'(leaf_q);
				code_bits   <= code_q;
				code_length <= LenBits'(len_q);
				last_code   <= (leaf_q == NIW'(n_q - 1'b1));
				leaf_q      <= leaf_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/huffman_code_builder_top.sv =====
// Flow: weights load while in_ready is high; after the closing word the build
// makes two scans over the i nodes below new node i and then a merge, for each
// new node; then each code is walked from its leaf up to the root and emitted.
// Throughput: one set at a time; the sequencer loads no new set while it builds or emits.
// Reset: arst_n clears the loaded count, sequencer and output valid; node RAMs
// are not cleared.
// ----------------------------------------------------------------------------
// huffman_code_builder_top
// Loads symbol weights, builds a Huffman tree and emits one code per symbol.
// ----------------------------------------------------------------------------
module huffman_code_builder_top
	import hcb_pkg::*;
#(
	parameter int unsigned MAX_SYMBOLS = 16,
	parameter int unsigned WEIGHT_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [WEIGHT_BITS-1:0] weight,
	input  logic                   last_weight,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [SymBits-1:0]     symbol,
	output logic [CodeBits-1:0]    code_bits,
	output logic [LenBits-1:0]     code_length,
	output logic                   last_code
);

	hcb_cmd_t    cmd;
	hcb_status_t status;

	hcb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .last_weight(last_weight),
		.in_ready(in_ready), .status(status), .cmd(cmd)
	);

	hcb_dp #(.MAX_SYMBOLS(MAX_SYMBOLS), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status), .weight(weight),
		.out_ready(out_ready), .out_valid(out_valid), .symbol(symbol),
		.code_bits(code_bits), .code_length(code_length), .last_code(last_code)
	);

`ifndef SYNTHESIS
	// the closing word starts a build, so no word can follow at once
	a_no_load_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_weight |=> !in_ready)
		else $error("word accepted right after closing word");

	// a non-final code on the output means the set is still being emitted
	a_no_load_mid_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_code |-> !in_ready)
		else $error("load open while a non-final code is held");
`endif

endmodule

// ===== bench/huffman_code_builder_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_builder_checker
// Watches both channels of the code builder, rebuilds each tree from the
// accepted weights and compares every emitted code against the prediction.
// ----------------------------------------------------------------------------
module huffman_code_builder_checker
	import hcb_pkg::*;
#(
	parameter int unsigned MAX_SYMBOLS = 16,
	parameter int unsigned WEIGHT_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [WEIGHT_BITS-1:0] weight,
	input  logic                   last_weight,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [SymBits-1:0]     symbol,
	input  logic [CodeBits-1:0]    code_bits,
	input  logic [LenBits-1:0]     code_length,
	input  logic                   last_code,
	output int                     fail_count,
	output int                     codes_pending
);

	localparam int unsigned NodeCount = 2 * MAX_SYMBOLS - 1;

	typedef struct packed {
		logic [SymBits-1:0]  sym;
		logic [CodeBits-1:0] bits;
		logic [LenBits-1:0]  len;
		logic                last;
	} code_word_t;

	code_word_t  code_q[$];
	logic [63:0] tree_wt[NodeCount];
	int unsigned tree_par[NodeCount];
	int unsigned tree_lft[NodeCount];
	int unsigned held_count;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch: %s got %0d expected %0d", what, got, want);
		fail_count++;
	endtask

	// lowest-weight orphan below limit, ties to the lowest index
	function automatic int unsigned lightest_orphan(input int unsigned limit);
		int unsigned best;
		bit found;
		best = 0;
		found = 0;
		for (int unsigned j = 0; j < limit; j++)
			if (tree_par[j] == 0 && (!found || tree_wt[j] < tree_wt[best])) begin
				best = j;
				found = 1;
			end
		return best;
	endfunction

	task automatic build_codes(input logic [WEIGHT_BITS-1:0] w, input logic fin);
		int unsigned n, m, a, b, c, f, len;
		logic [CodeBits-1:0] code;
		code_word_t cw;
		if (held_count < MAX_SYMBOLS) begin
			tree_wt[held_count] = 64'(w);
			tree_par[held_count] = 0;
			tree_lft[held_count] = 0;
			held_count++;
		end
		if (!fin)
			return;
		n = held_count;
		held_count = 0;
		if (n < 2)
			return;
		m = 2 * n - 1;
		for (int unsigned i = n; i < m; i++) begin
			tree_wt[i] = 0;
			tree_par[i] = 0;
			tree_lft[i] = 0;
		end
		for (int unsigned i = n; i < m; i++) begin
			a = lightest_orphan(i);
			tree_par[a] = i;
			b = lightest_orphan(i);
			tree_par[b] = i;
			tree_lft[i] = a;
			tree_wt[i] = tree_wt[a] + tree_wt[b];
		end
		for (int unsigned i = 0; i < n; i++) begin
			code = '0;
			len = 0;
			c = i;
			f = tree_par[i];
			while (f != 0 && f < m && len < NodeCount) begin
				if (tree_lft[f] != c && len < CodeBits)
					code[len] = 1'b1;
				len++;
				c = f;
				f = tree_par[f];
			end
			cw.sym = i[SymBits-1:0];
			cw.bits = code;
			cw.len = len[LenBits-1:0];
			cw.last = (i == n - 1);
			code_q.push_back(cw);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		code_word_t want;
		if (!arst_n) begin
			held_count = 0;
			fail_count = 0;
			codes_pending = code_q.size();
		end else begin
			if (in_valid && in_ready)
				build_codes(weight, last_weight);
			if (out_valid && out_ready) begin
				if (code_q.size() == 0) begin
					$display("unexpected code word for symbol %0d", symbol);
					fail_count++;
				end else begin
					want = code_q.pop_front();
					if (symbol !== want.sym) report("symbol", symbol, want.sym);
					if (code_bits !== want.bits) report("code_bits", code_bits, want.bits);
					if (code_length !== want.len) report("code_length", code_length, want.len);
					if (last_code !== want.last) report("last_code", last_code, want.last);
				end
			end
			codes_pending = code_q.size();
		end
	end

endmodule

// ===== bench/huffman_code_builder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_builder_top_tb
// Feeds directed and random weight sets to the code builder under
// random idling and back-pressure; the checker predicts and compares codes.
// ----------------------------------------------------------------------------
module huffman_code_builder_top_tb;
	import hcb_pkg::*;

	localparam int unsigned MaxSym   = 16;
	localparam int unsigned WtBits   = 16;
	localparam int          Watchdog = 40000;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [WtBits-1:0]   weight;
	logic                last_weight;
	logic                out_valid;
	logic                out_ready;
	logic [SymBits-1:0]  symbol;
	logic [CodeBits-1:0] code_bits;
	logic [LenBits-1:0]  code_length;
	logic                last_code;
	int                  fail_count;
	int                  codes_pending;
	int                  idle_cycles;
	bit                  hold_off;

	huffman_code_builder_top #(.MAX_SYMBOLS(MaxSym), .WEIGHT_BITS(WtBits)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.weight(weight), .last_weight(last_weight),
		.out_valid(out_valid), .out_ready(out_ready),
		.symbol(symbol), .code_bits(code_bits),
		.code_length(code_length), .last_code(last_code)
	);

	huffman_code_builder_checker #(.MAX_SYMBOLS(MaxSym), .WEIGHT_BITS(WtBits)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.weight(weight), .last_weight(last_weight),
		.out_valid(out_valid), .out_ready(out_ready),
		.symbol(symbol), .code_bits(code_bits),
		.code_length(code_length), .last_code(last_code),
		.fail_count(fail_count), .codes_pending(codes_pending)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int unsigned gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 60);
		if ($urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(1, 3);
	endfunction

	// hold the word until accepted, then idle for the given gap
	task automatic send_word(input logic [WtBits-1:0] w, input logic fin, input int unsigned gap);
		in_valid <= 1'b1;
		weight <= w;
		last_weight <= fin;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// the closing word of a set always drops valid afterwards
	task automatic send_set(input int unsigned n, input int unsigned mode, input bit idle);
		logic [WtBits-1:0] w;
		int unsigned gap;
		for (int unsigned i = 0; i < n; i++) begin
			case (mode)
				0: w = WtBits'($urandom);
				1: w = WtBits'($urandom_range(0, 7));
				2: w = 16'hFFFF;
				3: w = 16'h0000;
				default: w = WtBits'(1 << $urandom_range(0, 15));
			endcase
			gap = idle ? gap_len() : 0;
			if (i == n - 1 && gap == 0)
				gap = 1;
			send_word(w, i == n - 1, gap);
		end
	endtask

	task automatic drain();
		while (codes_pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// receiver: random stalls, with a long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (2000) @(negedge clk);
				hold_off = 0;
			end else if ($urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat (gap_len()) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= Watchdog) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int unsigned sent;
		int unsigned n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		weight = '0;
		last_weight = 1'b0;
		hold_off = 0;
		idle_cycles = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: single symbol, two symbols, extremes, ties, overflow
		send_set(1, 0, 0);
		send_set(2, 3, 0);
		send_set(2, 2, 0);
		send_set(3, 1, 0);
		send_word(16'h0001, 1'b0, 0);
		send_word(16'hFFFF, 1'b1, 0);
		send_word(16'h5555, 1'b0, 0);
		send_word(16'hAAAA, 1'b1, 1);
		drain();
		send_set(MaxSym + 2, 4, 0);
		drain();
		sent = 30;

		// block fills while the receiver holds off
		hold_off = 1;
		send_set(MaxSym, 2, 0);
		send_set(5, 0, 0);
		drain();
		sent += MaxSym + 5;

		while (sent < 350) begin
			case ($urandom_range(0, 9))
				0: n = 1;
				1: n = $urandom_range(MaxSym + 1, MaxSym + 3);
				2, 3: n = MaxSym;
				default: n = $urandom_range(2, 8);
			endcase
			send_set(n, $urandom_range(0, 4), $urandom_range(0, 3) != 0);
			if ($urandom_range(0, 7) == 0)
				drain();
			sent += n;
		end
		drain();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
design/hcb_pkg.sv
design/hcb_ram.sv
design/hcb_ctrl.sv
design/hcb_dp.sv
design/huffman_code_builder_top.sv
bench/huffman_code_builder_checker.sv
bench/huffman_code_builder_top_tb.sv
